// ----- rtl/boit_pkg.sv -----
// Shared types and constants for the backoff interval timer.
// Used by boit_mod_unit and backoff_interval_timer; depends on nothing.
`default_nettype none

package boit_pkg;

	localparam int unsigned IntervalWidth = 24;
	localparam int unsigned TimeWidth     = 32;
	localparam int unsigned MarginWidth   = 16;
	localparam int unsigned ModeWidth     = 2;
	localparam int unsigned FuncWidth     = 2;
	localparam int unsigned CfgIdxWidth   = 2;
	localparam int unsigned InDataWidth   = 80;
	localparam int unsigned OutDataWidth  = 40;

	// timer_mode codes
	localparam logic [ModeWidth-1:0] MODE_FIXED  = 2'd0;
	localparam logic [ModeWidth-1:0] MODE_EXP    = 2'd1;
	localparam logic [ModeWidth-1:0] MODE_RANDOM = 2'd2;

	// func codes; anything else is a poll
	localparam logic [FuncWidth-1:0] FUNC_RESET = 2'd0;
	localparam logic [FuncWidth-1:0] FUNC_STEP  = 2'd1;
	localparam logic [FuncWidth-1:0] FUNC_POLL  = 2'd2;

	// configuration register indexes
	localparam logic [CfgIdxWidth-1:0] REG_MODE    = 2'd0;
	localparam logic [CfgIdxWidth-1:0] REG_INITIAL = 2'd1;
	localparam logic [CfgIdxWidth-1:0] REG_MAX     = 2'd2;

	// remainder unit status toward the sequencer
	typedef struct packed {
		logic                     busy;
		logic [IntervalWidth-1:0] remainder;
	} boit_div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/backoff_interval_timer.sv -----
// Backoff interval timer top level: configuration registers, timer state,
// event sequencer and result register. Depends on boit_pkg and boit_mod_unit.
//
// Usage:
//   Write the timer mode (index 0), the starting interval (1) and the interval
//   cap (2) on the cfg port while the block is idle; cfg_ready is always high.
//   Events enter on s_axis: tuser carries func, tdata carries now_time,
//   random_word and margin. Every event gives exactly one item on m_axis
//   with next_fire_time, expired and running.
// Sequencing:
//   One event at a time. An event that needs a random interval (reset or
//   running step in random mode with max above initial) runs the bit-serial
//   remainder unit, one dividend bit per cycle, before the timer update; any
//   other event goes straight to the update. A new event is not taken until
//   the last one is through: s_axis_tready is high only while the sequencer is
//   idle, which it reenters at the clock edge that loads the result.
// Reset:
//   arst_n clears the timer (not running, interval 1, last fire 0), loads
//   the register defaults (fixed mode, initial 1, max 1) and drops any
//   pending result.
// Stall:
//   A result waiting on m_axis holds while m_axis_tready is low; the next
//   event is still accepted and is worked up to its result, then holds.
`default_nettype none

module backoff_interval_timer (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration write channel
	input  wire logic                                cfg_valid,
	output      logic                                cfg_ready,
	input  wire logic [boit_pkg::CfgIdxWidth-1:0]    cfg_index,
	input  wire logic [boit_pkg::IntervalWidth-1:0]  cfg_data,
	// event input
	input  wire logic                                s_axis_tvalid,
	output      logic                                s_axis_tready,
	// [31:0] now_time, [63:32] random_word, [79:64] margin
	input  wire logic [boit_pkg::InDataWidth-1:0]    s_axis_tdata,
	// [1:0] func
	input  wire logic [boit_pkg::FuncWidth-1:0]      s_axis_tuser,
	// result output
	output      logic                                m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// [31:0] next_fire_time, [32] expired, [33] running, [39:34] zero
	output      logic [boit_pkg::OutDataWidth-1:0]   m_axis_tdata
);
	import boit_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;
	localparam logic [1:0] ST_RES  = 2'd3;

	// configuration registers
	logic [ModeWidth-1:0]     mode_q;
	logic [IntervalWidth-1:0] initial_q;
	logic [IntervalWidth-1:0] max_q;

	// timer state
	logic                     running_q;
	logic [IntervalWidth-1:0] interval_q;
	logic [TimeWidth-1:0]     last_fire_q;

	// latched event
	logic [FuncWidth-1:0]     func_q;
	logic [TimeWidth-1:0]     now_q;
	logic [MarginWidth-1:0]   margin_q;
	logic                     step_idle_q;

	logic [1:0]               state_q;
	logic                     out_valid_q;
	logic [OutDataWidth-1:0]  out_data_q;

	logic [FuncWidth-1:0]     in_func;
	logic [TimeWidth-1:0]     in_now;
	logic [TimeWidth-1:0]     in_rnd;
	logic [MarginWidth-1:0]   in_margin;
	logic                     in_accept;
	logic                     span_ok;
	logic                     need_draw;
	logic [IntervalWidth-1:0] span;
	boit_div_rsp_t            div_rsp;

	logic [IntervalWidth-1:0] draw_val;
	logic [IntervalWidth:0]   doubled;
	logic [IntervalWidth-1:0] exp_val;
	logic [TimeWidth:0]       fire_sum;
	logic [TimeWidth+1:0]     threshold;
	logic                     expired;

	assign in_func   = s_axis_tuser;
	assign in_now    = s_axis_tdata[31:0];
	assign in_rnd    = s_axis_tdata[63:32];
	assign in_margin = s_axis_tdata[79:64];

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// random draw only when the range is non-empty
	assign span_ok   = (max_q > initial_q);
	assign span      = max_q - initial_q;
	assign need_draw = span_ok && (mode_q == MODE_RANDOM) &&
		((in_func == FUNC_RESET) || ((in_func == FUNC_STEP) && running_q));

	boit_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_accept && need_draw),
		.dividend (in_rnd),
		.divisor  (span),
		.rsp      (div_rsp)
	);

	// candidate intervals; remainder is below span so the sum stays in range
	always_comb begin
		draw_val = span_ok ? (initial_q + div_rsp.remainder) : initial_q;
		doubled  = {interval_q, 1'b0};
		if (interval_q >= max_q) begin
			exp_val = interval_q;
		end else if (doubled > {1'b0, max_q}) begin
			exp_val = max_q;
		end else begin
			exp_val = doubled[IntervalWidth-1:0];
		end
	end

	// result: next fire wraps, the expiry threshold does not
	always_comb begin
		fire_sum  = {1'b0, last_fire_q} + {{(TimeWidth+1-IntervalWidth){1'b0}}, interval_q};
		threshold = {1'b0, fire_sum} + {{(TimeWidth+2-MarginWidth){1'b0}}, margin_q};
		expired   = ({2'b00, now_q} >= threshold);
	end

	// configuration writes; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_FIXED;
			initial_q <= IntervalWidth'(1);
			max_q     <= IntervalWidth'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:    mode_q    <= cfg_data[ModeWidth-1:0];
				REG_INITIAL: initial_q <= cfg_data;
				REG_MAX:     max_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// hold the event fields for the whole sequence
	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_q   <= in_func;
			now_q    <= in_now;
			margin_q <= in_margin;
		end
	end

	// sequencer and timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			running_q   <= 1'b0;
			interval_q  <= IntervalWidth'(1);
			last_fire_q <= '0;
			step_idle_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= need_draw ? ST_DIV : ST_UPD;
					end
				end
				ST_DIV: begin
					// wait for the remainder unit to finish
					if (!div_rsp.busy) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					// a step before any reset changes nothing and reports no fire time
					step_idle_q <= (func_q == FUNC_STEP) && !running_q;
					case (func_q)
						FUNC_RESET: begin
							running_q   <= 1'b1;
							interval_q  <= (mode_q == MODE_RANDOM) ? draw_val : initial_q;
							last_fire_q <= now_q;
						end
						FUNC_STEP: begin
							if (running_q) begin
								// advance by the old interval, then pick the new one
								last_fire_q <= last_fire_q +
									{{(TimeWidth-IntervalWidth){1'b0}}, interval_q};
								case (mode_q)
									MODE_EXP:    interval_q <= exp_val;
									MODE_RANDOM: interval_q <= draw_val;
									default: ;
								endcase
							end
						end
						default: ;
					endcase
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (!out_valid_q || m_axis_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_RES) && (!out_valid_q || m_axis_tready)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RES) && (!out_valid_q || m_axis_tready)) begin
			out_data_q <= {{(OutDataWidth-TimeWidth-2){1'b0}}, running_q, expired,
				step_idle_q ? {TimeWidth{1'b0}} : fire_sum[TimeWidth-1:0]};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ----- rtl/boit_mod_unit.sv -----
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on boit_pkg.
`default_nettype none

module boit_mod_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic [boit_pkg::TimeWidth-1:0]      dividend,
	input  wire logic [boit_pkg::IntervalWidth-1:0]  divisor,
	output boit_pkg::boit_div_rsp_t                  rsp
);
	import boit_pkg::*;

	localparam int unsigned CntWidth = $clog2(TimeWidth);

	logic                     busy_q;
	logic [CntWidth-1:0]      cnt_q;
	logic [TimeWidth-1:0]     dvd_q;
	logic [IntervalWidth-1:0] dsr_q;
	logic [IntervalWidth-1:0] rem_q;
	logic [IntervalWidth:0]   trial;
	logic [IntervalWidth:0]   diff;
	logic [IntervalWidth-1:0] rem_next;

	// shift in the next dividend bit, subtract when the divisor fits
	always_comb begin
		trial = {rem_q, dvd_q[TimeWidth-1]};
		diff  = trial - {1'b0, dsr_q};
		if (trial >= {1'b0, dsr_q}) begin
			rem_next = diff[IntervalWidth-1:0];
		end else begin
			rem_next = trial[IntervalWidth-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CntWidth'(TimeWidth - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[TimeWidth-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.remainder = rem_q;

endmodule

`default_nettype wire

// ----- tb/sv/tb_backoff_interval_timer.sv -----
// Self-checking testbench for backoff_interval_timer: predicts every result item
// from its own copy of the timer state and checks the m_axis stream against it.
// Depends on boit_pkg and the backoff_interval_timer RTL.
`timescale 1ns / 100ps

module tb_backoff_interval_timer;
	import boit_pkg::*;

	// Codes the package leaves unnamed: they still have defined behavior.
	localparam logic [FuncWidth-1:0] FUNC_SPARE = 2'd3; // acts as a poll
	localparam logic [ModeWidth-1:0] MODE_SPARE = 2'd3; // acts as fixed mode

	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES   = 40;
	localparam int unsigned RANDOM_PHASES  = 10;
	localparam int unsigned PHASE_ITEMS    = 100;

	typedef struct packed {
		logic [FuncWidth-1:0]   func;
		logic [TimeWidth-1:0]   now_t;
		logic [TimeWidth-1:0]   rnd_word;
		logic [MarginWidth-1:0] margin;
	} timer_event_t;

	typedef struct packed {
		logic [TimeWidth-1:0] next_fire;
		logic                 expired;
		logic                 running;
	} fire_result_t;

	// Timer predictor plus the queue of fire results still owed by the block.
	class fire_time_board;
		logic [ModeWidth-1:0]     cfg_mode;
		logic [IntervalWidth-1:0] cfg_initial;
		logic [IntervalWidth-1:0] cfg_max;
		bit                       tmr_running;
		logic [IntervalWidth-1:0] tmr_interval;
		logic [TimeWidth-1:0]     tmr_last_fire;
		fire_result_t             pending_fires[$];
		int unsigned              errors;

		function new();
			cfg_mode      = MODE_FIXED;
			cfg_initial   = 1;
			cfg_max       = 1;
			tmr_running   = 0;
			tmr_interval  = 1;
			tmr_last_fire = 0;
			errors        = 0;
		endfunction

		function void set_reg(logic [CfgIdxWidth-1:0] idx, logic [IntervalWidth-1:0] val);
			case (idx)
				REG_MODE:    cfg_mode    = val[ModeWidth-1:0];
				REG_INITIAL: cfg_initial = val;
				REG_MAX:     cfg_max     = val;
				default: ;
			endcase
		endfunction

		// Random interval lies in [initial, max); a flat or inverted range gives initial.
		function logic [IntervalWidth-1:0] draw_interval(logic [TimeWidth-1:0] rnd_word);
			logic [TimeWidth-1:0] span;
			logic [TimeWidth-1:0] offset;
			if (cfg_max > cfg_initial) begin
				span   = 32'(cfg_max - cfg_initial);
				offset = rnd_word % span;
				return cfg_initial + offset[IntervalWidth-1:0];
			end
			return cfg_initial;
		endfunction

		function void note_event(timer_event_t ev);
			logic [IntervalWidth-1:0] prior;
			logic [IntervalWidth:0]   doubled;
			logic [TimeWidth+1:0]     threshold;
			bit                       idle_step;
			fire_result_t             want;
			idle_step = 0;
			case (ev.func)
				FUNC_RESET: begin
					tmr_running   = 1;
					tmr_interval  = (cfg_mode == MODE_RANDOM) ? draw_interval(ev.rnd_word)
					                                          : cfg_initial;
					tmr_last_fire = ev.now_t;
				end
				FUNC_STEP: begin
					if (tmr_running) begin
						prior = tmr_interval;
						if (cfg_mode == MODE_EXP) begin
							// double toward the cap, hold once at or above it
							if (tmr_interval < cfg_max) begin
								doubled = {tmr_interval, 1'b0};
								if (doubled > {1'b0, cfg_max})
									doubled = {1'b0, cfg_max};
								tmr_interval = doubled[IntervalWidth-1:0];
							end
						end else if (cfg_mode == MODE_RANDOM) begin
							tmr_interval = draw_interval(ev.rnd_word);
						end
						tmr_last_fire = tmr_last_fire + 32'(prior);
					end else begin
						idle_step = 1;
					end
				end
				default: ;
			endcase
			// expiry sum is formed without wrapping, so an overflow never expires
			threshold = 34'(tmr_last_fire) + 34'(tmr_interval) + 34'(ev.margin);
			want.next_fire = idle_step ? '0 : tmr_last_fire + 32'(tmr_interval);
			want.expired   = (34'(ev.now_t) >= threshold);
			want.running   = tmr_running;
			pending_fires.push_back(want);
		endfunction

		function void check_result(logic [OutDataWidth-1:0] data);
			fire_result_t want;
			fire_result_t got;
			got.next_fire = data[31:0];
			got.expired   = data[32];
			got.running   = data[33];
			if (pending_fires.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result item %h", data);
				return;
			end
			want = pending_fires.pop_front();
			if (got.next_fire !== want.next_fire || got.expired !== want.expired ||
			    got.running !== want.running) begin
				errors++;
				if (errors <= 10)
					$display({"result mismatch: next_fire exp %h got %h, ",
					          "expired exp %b got %b, running exp %b got %b"},
					         want.next_fire, got.next_fire, want.expired, got.expired,
					         want.running, got.running);
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CfgIdxWidth-1:0]   cfg_index;
	logic [IntervalWidth-1:0] cfg_data;
	logic                     s_axis_tvalid;
	logic                     s_axis_tready;
	logic [InDataWidth-1:0]   s_axis_tdata;  // [31:0] now_time, [63:32] random_word, [79:64] margin
	logic [FuncWidth-1:0]     s_axis_tuser;  // [1:0] func
	logic                     m_axis_tvalid;
	logic                     m_axis_tready;
	logic [OutDataWidth-1:0]  m_axis_tdata;  // [31:0] next_fire_time, [32] expired, [33] running

	fire_time_board board;
	bit             no_idle;
	int unsigned    idle_cycles;
	int unsigned    ready_hold;

	backoff_interval_timer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Mostly short gaps, now and then a long one; none in a no-idle stretch.
	function int unsigned pick_gap();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Favor small intervals so expiry and doubling flip often; keep the extremes.
	function logic [IntervalWidth-1:0] pick_interval();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			5:       return IntervalWidth'($urandom);
			default: return IntervalWidth'($urandom_range(1, 64));
		endcase
	endfunction

	function logic [ModeWidth-1:0] pick_mode();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return MODE_FIXED;
		if (r < 6)
			return MODE_EXP;
		if (r < 9)
			return MODE_RANDOM;
		return MODE_SPARE;
	endfunction

	// Present one event item after a random gap and hold it until accepted.
	task automatic send_event(input logic [FuncWidth-1:0] func, input logic [TimeWidth-1:0] now_t,
	                          input logic [TimeWidth-1:0] rnd_word,
	                          input logic [MarginWidth-1:0] margin);
		int unsigned  gap;
		timer_event_t ev;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = func;
		s_axis_tdata  = {margin, rnd_word, now_t};
		ev = '{func: func, now_t: now_t, rnd_word: rnd_word, margin: margin};
		do @(posedge clk); while (!s_axis_tready);
		board.note_event(ev);
	endtask

	// Drop valid and wait until every owed result item has come back.
	task automatic finish_events();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (board.pending_fires.size() > 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [IntervalWidth-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, val);
	endtask

	// The user must change registers only with the block idle (the block does not enforce it), so drain first.
	task automatic configure(input logic [ModeWidth-1:0] mode, input logic [IntervalWidth-1:0] init_iv,
	                         input logic [IntervalWidth-1:0] max_iv);
		finish_events();
		write_reg(REG_MODE, IntervalWidth'(mode));
		write_reg(REG_INITIAL, init_iv);
		write_reg(REG_MAX, max_iv);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic random_phase(input int unsigned count);
		logic [FuncWidth-1:0]   func;
		logic [TimeWidth-1:0]   now_t;
		logic [MarginWidth-1:0] margin;
		int unsigned            r;
		for (int unsigned i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 15)
				func = FUNC_RESET;
			else if (r < 60)
				func = FUNC_STEP;
			else if (r < 90)
				func = FUNC_POLL;
			else
				func = FUNC_SPARE;
			// open most phases with a restart so the step sequence is well formed
			if (i == 0 && $urandom_range(0, 3) != 0)
				func = FUNC_RESET;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: margin = MarginWidth'($urandom_range(0, 8));
				5, 6:          margin = '1;
				default:       margin = MarginWidth'($urandom);
			endcase
			// aim now near the current threshold so expiry lands on both sides
			if ($urandom_range(0, 9) < 4)
				now_t = $urandom;
			else
				now_t = board.tmr_last_fire + 32'(board.tmr_interval) + 32'(margin)
				        + 32'($urandom_range(0, 6)) - 32'd3;
			send_event(func, now_t, $urandom, margin);
		end
	endtask

	// Receiver: alternate ready-high stretches with random stalls.
	initial begin
		m_axis_tready = 1'b0;
		ready_hold    = 0;
		forever begin
			@(negedge clk);
			if (ready_hold > 0) begin
				ready_hold--;
			end else if (m_axis_tready) begin
				ready_hold = pick_gap();
				if (ready_hold > 0) begin
					m_axis_tready = 1'b0;
					ready_hold--;
				end else begin
					ready_hold = $urandom_range(0, 15);
				end
			end else begin
				m_axis_tready = 1'b1;
				ready_hold    = $urandom_range(0, 15);
			end
		end
	end

	// Check every result item as it is accepted.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_result(m_axis_tdata);
	end

	// End the run when no channel has moved an item for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		board         = new();
		no_idle       = 0;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = FUNC_POLL;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Register defaults: step while idle, a named and an unnamed poll, then start.
		send_event(FUNC_STEP, 32'd0, 32'd0, 16'd0);
		send_event(FUNC_POLL, 32'd0, 32'hFFFF_FFFF, 16'd0);
		send_event(FUNC_SPARE, 32'hFFFF_FFFF, 32'd0, 16'hFFFF);
		send_event(FUNC_RESET, 32'd100, 32'd0, 16'd0);
		send_event(FUNC_POLL, 32'd101, 32'd0, 16'd0);
		send_event(FUNC_STEP, 32'hFFFF_FFFF, 32'd0, 16'hFFFF);

		// Exponential doubling up to the cap.
		configure(MODE_EXP, 24'd1, 24'd20);
		send_event(FUNC_RESET, 32'd0, 32'd0, 16'd0);
		repeat (5) send_event(FUNC_STEP, 32'd40, 32'd0, 16'd1);

		// Random draws across the range, including the largest random word.
		configure(MODE_RANDOM, 24'd10, 24'd1000);
		send_event(FUNC_RESET, 32'd5000, 32'hFFFF_FFFF, 16'd0);
		send_event(FUNC_STEP, 32'd5000, 32'd0, 16'd0);
		send_event(FUNC_STEP, 32'd5000, 32'd12345, 16'd0);

		// Random mode with a flat range falls back to the initial interval.
		configure(MODE_RANDOM, 24'd50, 24'd50);
		send_event(FUNC_RESET, 32'd7, 32'hDEAD_BEEF, 16'd0);
		send_event(FUNC_STEP, 32'd200, 32'h1234_5678, 16'd0);

		// Inverted range, plus an expiry sum that runs past 32 bits.
		configure(MODE_RANDOM, 24'hFF_FFFF, 24'd0);
		send_event(FUNC_RESET, 32'hFFFF_FF00, 32'h0BAD_F00D, 16'd0);
		send_event(FUNC_POLL, 32'hFFFF_FFFF, 32'd0, 16'hFFFF);
		send_event(FUNC_STEP, 32'hFFFF_FFFF, 32'd99, 16'd0);

		// Unused mode code: fixed behavior with a zero interval.
		configure(MODE_SPARE, 24'd0, 24'hFF_FFFF);
		send_event(FUNC_RESET, 32'd10, 32'd3, 16'd0);
		send_event(FUNC_STEP, 32'd10, 32'd3, 16'd0);
		send_event(FUNC_POLL, 32'd10, 32'd3, 16'd0);

		// Doubling that overshoots the cap gets clipped to it.
		configure(MODE_EXP, 24'h80_0000, 24'hFF_FFFF);
		send_event(FUNC_RESET, 32'd0, 32'd0, 16'd0);
		send_event(FUNC_STEP, 32'd0, 32'd0, 16'd0);

		// Random phases: fresh settings each time, some without any idling.
		for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
			configure(pick_mode(), pick_interval(), pick_interval());
			no_idle = ($urandom_range(0, 3) == 0);
			random_phase(PHASE_ITEMS);
		end

		no_idle = 0;
		finish_events();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending_fires.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
